FILE: src/assert_macros.svh
// assertion macros shared by the sorter rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define BIS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sorter assertion failed");

// condition must never be true at a clock edge out of reset
`define BIS_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("sorter forbidden condition seen");

`endif

FILE: src/bis_pkg.sv
// shared types and constants of the binary insertion sorter
// no dependencies
`default_nettype none

package bis_pkg;

  localparam int unsigned DefMaxElements = 64;
  localparam int unsigned DefDataWidth   = 32;
  localparam int unsigned PortWidth      = 32;

  localparam int unsigned MoveWidth = 13;
  localparam int unsigned CmpWidth  = 9;

  localparam logic [MoveWidth-1:0] MovesPerShift = MoveWidth'(3);
  localparam logic [MoveWidth-1:0] MoveLimit     = '1;
  localparam logic [CmpWidth-1:0]  CmpLimit      = '1;

  // commands from the sequencer to the statistics counters
  typedef struct packed {
    logic clear;
    logic cmp_inc;
    logic move_inc;
    logic ovf_set;
  } stats_cmd_t;

endpackage

`default_nettype wire

FILE: src/bis_store.sv
// sorted element store: one write port, one read port, registered read data
// depends on assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module bis_store #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

  // the shift pipeline always reads below the entry it writes
  `BIS_NEVER(a_no_rw_collision, we_i && re_i && (waddr_i == raddr_i))

endmodule

`default_nettype wire

FILE: src/bis_stats.sv
// comparison and move counters with saturation, plus the overflow mark
// depends on bis_pkg
`default_nettype none

module bis_stats (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire bis_pkg::stats_cmd_t          cmd_i,
  output logic [bis_pkg::MoveWidth-1:0]     move_count_o,
  output logic [bis_pkg::CmpWidth-1:0]      compare_count_o,
  output logic                              overflow_o
);

  import bis_pkg::*;

  logic [MoveWidth-1:0] moves_q, moves_d;
  logic [CmpWidth-1:0]  cmps_q, cmps_d;
  logic                 ovf_q, ovf_d;

  always_comb begin
    moves_d = moves_q;
    cmps_d  = cmps_q;
    ovf_d   = ovf_q;
    if (cmd_i.clear) begin
      moves_d = '0;
      cmps_d  = '0;
      ovf_d   = 1'b0;
    end else begin
      if (cmd_i.move_inc) begin
        if (moves_q <= MoveLimit - MovesPerShift) begin
          moves_d = moves_q + MovesPerShift;
        end else begin
          moves_d = MoveLimit;
        end
      end
      if (cmd_i.cmp_inc && (cmps_q < CmpLimit)) begin
        cmps_d = cmps_q + 1'b1;
      end
      if (cmd_i.ovf_set) begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      moves_q <= '0;
      cmps_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      moves_q <= moves_d;
      cmps_q  <= cmps_d;
      ovf_q   <= ovf_d;
    end
  end

  assign move_count_o    = moves_q;
  assign compare_count_o = cmps_q;
  assign overflow_o      = ovf_q;

endmodule

`default_nettype wire

FILE: src/binary_insertion_sorter_unit.sv
// each binary search step of a word reads the midpoint from the store, then compares;
//   each greater entry is then shifted up one slot through the one-read one-write store
// throughput: one word at a time; busy stays high until its insertion and any emission end
// a final word then streams the set out in order, one result per cycle, no stall
// reset is asynchronous; it empties the set and clears the counters, store is not cleared
`default_nettype none

`include "assert_macros.svh"

module binary_insertion_sorter_unit #(
  parameter int unsigned MAX_ELEMENTS = bis_pkg::DefMaxElements,
  parameter int unsigned DATA_WIDTH   = bis_pkg::DefDataWidth
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [bis_pkg::PortWidth-1:0]   element_value_i,
  input  wire logic                            final_element_i,
  output logic                                 result_valid_o,
  output logic [bis_pkg::PortWidth-1:0]        sorted_value_o,
  output logic                                 last_result_o,
  output logic [bis_pkg::MoveWidth-1:0]        move_count_o,
  output logic [bis_pkg::CmpWidth-1:0]         compare_count_o,
  output logic                                 overflow_flag_o
);

  import bis_pkg::*;

  // store addresses and counts of entries (count reaches the depth itself)
  localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CW-1:0] MaxCount = CW'(MAX_ELEMENTS);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;  // issue read of the midpoint
  localparam logic [2:0] S_SWAIT  = 3'd2;  // compare against read data
  localparam logic [2:0] S_SHIFT  = 3'd3;  // read j-1, write j, pipelined
  localparam logic [2:0] S_PLACE  = 3'd4;  // write new word at its slot
  localparam logic [2:0] S_EMIT   = 3'd5;  // stream the set out in order
  localparam logic [2:0] S_DRAIN  = 3'd6;  // last result on the ports

  logic [2:0]            state_q, state_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic                  fin_q, fin_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         lo_q, lo_d;
  logic [CW-1:0]         hi_q, hi_d;
  logic [CW-1:0]         j_q, j_d;
  logic                  pend_q, pend_d;
  logic [AW-1:0]         widx_q, widx_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_last_q, out_last_d;

  logic [DATA_WIDTH-1:0] elem_in;
  logic [CW-1:0]         mid;
  logic [CW-1:0]         jm1;
  logic [CW-1:0]         jp1;

  // store port signals
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

  stats_cmd_t           stats_cmd;
  logic [MoveWidth-1:0] moves_total;
  logic [CmpWidth-1:0]  cmps_total;
  logic                 ovf_seen;

  // fit the port word to the internal data width
  if (DATA_WIDTH > PortWidth) begin : g_in_wide
    assign elem_in = {{(DATA_WIDTH - PortWidth){1'b0}}, element_value_i};
    assign sorted_value_o = mem_rdata[PortWidth-1:0];
  end else if (DATA_WIDTH == PortWidth) begin : g_in_same
    assign elem_in = element_value_i;
    assign sorted_value_o = mem_rdata;
  end else begin : g_in_narrow
    assign elem_in = element_value_i[DATA_WIDTH-1:0];
    assign sorted_value_o = {{(PortWidth - DATA_WIDTH){1'b0}}, mem_rdata};
  end

  // midpoint of the open search window, upper bound excluded
  assign mid = lo_q + ((hi_q - lo_q) >> 1);
  assign jm1 = j_q - 1'b1;
  assign jp1 = j_q + 1'b1;

  always_comb begin
    state_d     = state_q;
    val_d       = val_q;
    fin_d       = fin_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    j_d         = j_q;
    pend_d      = pend_q;
    widx_d      = widx_q;
    out_valid_d = 1'b0;
    out_last_d  = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = widx_q;
    mem_wdata   = mem_rdata;
    mem_re      = 1'b0;
    mem_raddr   = mid[AW-1:0];
    stats_cmd   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          val_d = elem_in;
          fin_d = final_element_i;
          if (count_q < MaxCount) begin
            lo_d    = '0;
            hi_d    = count_q;
            state_d = S_SEARCH;
          end else begin
            // store full: word dropped, a final word still closes the set
            stats_cmd.ovf_set = 1'b1;
            if (final_element_i) begin
              j_d     = '0;
              state_d = S_EMIT;
            end
          end
        end
      end

      S_SEARCH: begin
        if (lo_q < hi_q) begin
          mem_re    = 1'b1;
          mem_raddr = mid[AW-1:0];
          state_d   = S_SWAIT;
        end else begin
          // slot found at lo, start moving the greater entries up
          j_d     = count_q;
          pend_d  = 1'b0;
          state_d = S_SHIFT;
        end
      end

      S_SWAIT: begin
        stats_cmd.cmp_inc = 1'b1;
        // equal values go right of stored ones to keep the order stable
        if (val_q >= mem_rdata) begin
          lo_d = mid + 1'b1;
        end else begin
          hi_d = mid;
        end
        state_d = S_SEARCH;
      end

      S_SHIFT: begin
        // retire the entry read last cycle one slot higher
        if (pend_q) begin
          mem_we             = 1'b1;
          mem_waddr          = widx_q;
          mem_wdata          = mem_rdata;
          stats_cmd.move_inc = 1'b1;
        end
        if (j_q > lo_q) begin
          mem_re    = 1'b1;
          mem_raddr = jm1[AW-1:0];
          pend_d    = 1'b1;
          widx_d    = j_q[AW-1:0];
          j_d       = jm1;
        end else begin
          pend_d  = 1'b0;
          state_d = S_PLACE;
        end
      end

      S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = lo_q[AW-1:0];
        mem_wdata = val_q;
        count_d   = count_q + 1'b1;
        if (fin_q) begin
          j_d     = '0;
          state_d = S_EMIT;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_EMIT: begin
        // read entry j now, it shows on the ports next cycle
        mem_re      = 1'b1;
        mem_raddr   = j_q[AW-1:0];
        out_valid_d = 1'b1;
        out_last_d  = (jp1 == count_q);
        j_d         = jp1;
        if (jp1 == count_q) begin
          state_d = S_DRAIN;
        end
      end

      S_DRAIN: begin
        // last result is out this cycle; start a fresh set behind it
        stats_cmd.clear = 1'b1;
        count_d         = '0;
        state_d         = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fin_q       <= 1'b0;
      count_q     <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      j_q         <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      fin_q       <= fin_d;
      count_q     <= count_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      j_q         <= j_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    widx_q <= widx_d;
  end

  bis_store #(
    .Depth (MAX_ELEMENTS),
    .Width (DATA_WIDTH)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bis_stats u_stats (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (stats_cmd),
    .move_count_o    (moves_total),
    .compare_count_o (cmps_total),
    .overflow_o      (ovf_seen)
  );

  // the block is busy whenever it is not waiting for a word
  assign busy = (state_q != S_IDLE);

  // result word comes straight from the store's read register
  assign result_valid_o  = out_valid_q;
  assign last_result_o   = out_last_q;
  assign move_count_o    = out_last_q ? moves_total : '0;
  assign compare_count_o = out_last_q ? cmps_total : '0;
  assign overflow_flag_o = out_valid_q & ovf_seen;

  `BIS_ASSERT(a_result_while_busy, result_valid_o |-> busy)
  `BIS_ASSERT(a_last_is_valid, last_result_o |-> result_valid_o)
  `BIS_NEVER(a_count_in_range, count_q > MaxCount)
  `BIS_ASSERT(a_last_then_clear, last_result_o |=> (count_q == '0) && !result_valid_o)

endmodule

`default_nettype wire

FILE: tb/tb_binary_insertion_sorter_unit.sv
// self-checking testbench of binary_insertion_sorter_unit: drives sets of words, predicts
// the sorted output with a behavioral insertion sort and compares every result word
// depends on bis_pkg and the sorter rtl
`timescale 1ns / 1ps

module tb_binary_insertion_sorter_unit;
  import bis_pkg::*;

  // one emitted result word
  typedef struct packed {
    logic [PortWidth-1:0] value;
    logic                 last;
    logic [MoveWidth-1:0] moves;
    logic [CmpWidth-1:0]  compares;
    logic                 overflow;
  } sorted_word_t;

  // one row of the directed table; fixed_check marks a typed-in expectation
  typedef struct packed {
    logic [PortWidth-1:0] value;
    logic                 fin;
    logic                 fixed_check;
    sorted_word_t         fixed_word;
  } stim_row_t;

  localparam int unsigned NumDirected = 18;
  localparam int unsigned RandomItems = 320;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned DrainCycles = 200;

  // value shapes used by the random sets
  typedef enum int unsigned {
    ValFull,
    ValFewDistinct,
    ValExtremes,
    ValNearTop
  } value_shape_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic [PortWidth-1:0]   element_value_i;
  logic                   final_element_i;
  logic                   result_valid_o;
  logic [PortWidth-1:0]   sorted_value_o;
  logic                   last_result_o;
  logic [MoveWidth-1:0]   move_count_o;
  logic [CmpWidth-1:0]    compare_count_o;
  logic                   overflow_flag_o;

  binary_insertion_sorter_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .element_value_i (element_value_i),
    .final_element_i (final_element_i),
    .result_valid_o  (result_valid_o),
    .sorted_value_o  (sorted_value_o),
    .last_result_o   (last_result_o),
    .move_count_o    (move_count_o),
    .compare_count_o (compare_count_o),
    .overflow_flag_o (overflow_flag_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // behavioral copy of the sorter state
  logic [PortWidth-1:0] sort_store [DefMaxElements];
  int unsigned          sort_count;
  logic [MoveWidth-1:0] sort_moves;
  logic [CmpWidth-1:0]  sort_compares;
  logic                 sort_overflow;

  sorted_word_t fresh_words_q [$];   // words produced by the latest accepted element
  sorted_word_t pending_words_q [$]; // words still owed by the dut, oldest first

  int unsigned fail_count;
  int unsigned items_sent;
  bit          no_idle;

  // directed part: extremes as one-word sets, then duplicates, reversed and ordered input, and mixed extremes
  stim_row_t directed_rows [NumDirected] = '{
    '{32'h0000_0000, 1'b1, 1'b1, '{32'h0000_0000, 1'b1, 13'd0, 9'd0, 1'b0}},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, '{32'hFFFF_FFFF, 1'b1, 13'd0, 9'd0, 1'b0}},
    '{32'h0000_0001, 1'b1, 1'b1, '{32'h0000_0001, 1'b1, 13'd0, 9'd0, 1'b0}},
    '{32'd5,         1'b0, 1'b0, '0},
    '{32'd3,         1'b0, 1'b0, '0},
    '{32'd5,         1'b0, 1'b0, '0},
    '{32'd3,         1'b1, 1'b0, '0},
    '{32'd40,        1'b0, 1'b0, '0},
    '{32'd30,        1'b0, 1'b0, '0},
    '{32'd20,        1'b0, 1'b0, '0},
    '{32'd10,        1'b1, 1'b0, '0},
    '{32'd1,         1'b0, 1'b0, '0},
    '{32'd2,         1'b0, 1'b0, '0},
    '{32'd3,         1'b1, 1'b0, '0},
    '{32'h0000_0000, 1'b0, 1'b0, '0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{32'h8000_0000, 1'b0, 1'b0, '0},
    '{32'h7FFF_FFFF, 1'b1, 1'b0, '0}
  };

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MaxReports) begin
      $display("mismatch %0d: %s", fail_count, msg);
    end
  endfunction

  // stable binary insertion; a final element flushes the set into fresh_words_q
  function automatic void sort_in_element(input logic [PortWidth-1:0] value, input logic fin);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    sorted_word_t word;
    lo = 0;
    hi = sort_count;
    fresh_words_q.delete();
    if (sort_count < DefMaxElements) begin
      // search lands after all equal entries
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (sort_compares != CmpLimit) begin
          sort_compares++;
        end
        if (value >= sort_store[mid]) begin
          lo = mid + 1;
        end else begin
          hi = mid;
        end
      end
      for (int unsigned j = sort_count; j > lo; j--) begin
        sort_store[j] = sort_store[j-1];
        if (sort_moves <= MoveLimit - MovesPerShift) begin
          sort_moves += MovesPerShift;
        end else begin
          sort_moves = MoveLimit;
        end
      end
      sort_store[lo] = value;
      sort_count++;
    end else begin
      sort_overflow = 1'b1;
    end
    if (fin) begin
      for (int unsigned k = 0; k < sort_count; k++) begin
        word.value    = sort_store[k];
        word.last     = (k + 1 == sort_count);
        word.moves    = word.last ? sort_moves : '0;
        word.compares = word.last ? sort_compares : '0;
        word.overflow = sort_overflow;
        fresh_words_q.push_back(word);
      end
      sort_count    = 0;
      sort_moves    = '0;
      sort_compares = '0;
      sort_overflow = 1'b0;
    end
  endfunction

  // hand one word to the dut; called at a rising edge, returns at a rising edge
  task automatic send_element(input logic [PortWidth-1:0] value, input logic fin,
                              input logic fixed_check, input sorted_word_t fixed_word);
    int unsigned gap;
    start           <= 1'b1;
    element_value_i <= value;
    final_element_i <= fin;
    do @(posedge clk_i); while (busy !== 1'b0);
    items_sent++;
    sort_in_element(value, fin);
    if (fixed_check) begin
      pending_words_q.push_back(fixed_word);
    end else begin
      foreach (fresh_words_q[i]) pending_words_q.push_back(fresh_words_q[i]);
    end
    // start stays high across a zero gap so back-to-back words need no toggle
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // sender holds off until every owed word has come out
  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_words_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [PortWidth-1:0] pick_value(input value_shape_e shape);
    case (shape)
      ValFewDistinct: pick_value = PortWidth'($urandom_range(0, 7));
      ValExtremes: begin
        case ($urandom_range(0, 3))
          0:       pick_value = '0;
          1:       pick_value = '1;
          2:       pick_value = 32'h8000_0000;
          default: pick_value = 32'h7FFF_FFFF;
        endcase
      end
      ValNearTop: pick_value = 32'hFFFF_FFF0 | PortWidth'($urandom_range(0, 15));
      default:    pick_value = $urandom();
    endcase
  endfunction

  // one whole set of random words, the last one flagged final
  task automatic send_set(input int unsigned length);
    value_shape_e shape;
    shape   = value_shape_e'($urandom_range(0, 3));
    no_idle = ($urandom_range(0, 3) == 0);
    for (int unsigned n = 0; n < length; n++) begin
      send_element(pick_value(shape), n + 1 == length, 1'b0, '0);
    end
  endtask

  // result checker: the dut cannot be stalled, so every strobe is taken
  always @(posedge clk_i) begin
    sorted_word_t got;
    sorted_word_t want;
    if (rst_ni === 1'b1 && result_valid_o === 1'b1) begin
      got = '{sorted_value_o, last_result_o, move_count_o, compare_count_o, overflow_flag_o};
      if (pending_words_q.size() == 0) begin
        note_failure($sformatf("unexpected word value=%h last=%b moves=%0d cmps=%0d ovf=%b",
                               got.value, got.last, got.moves, got.compares, got.overflow));
      end else begin
        want = pending_words_q.pop_front();
        if (got.value !== want.value || got.last !== want.last || got.moves !== want.moves ||
            got.compares !== want.compares || got.overflow !== want.overflow) begin
          note_failure($sformatf(
            "exp value=%h last=%b moves=%0d cmps=%0d ovf=%b, got value=%h last=%b moves=%0d cmps=%0d ovf=%b",
            want.value, want.last, want.moves, want.compares, want.overflow,
            got.value, got.last, got.moves, got.compares, got.overflow));
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    start           = 1'b0;
    element_value_i = '0;
    final_element_i = 1'b0;
    sort_count      = 0;
    sort_moves      = '0;
    sort_compares   = '0;
    sort_overflow   = 1'b0;
    fail_count      = 0;
    items_sent      = 0;
    no_idle         = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (directed_rows[r]) begin
      send_element(directed_rows[r].value, directed_rows[r].fin,
                   directed_rows[r].fixed_check, directed_rows[r].fixed_word);
    end
    wait_for_results();

    // exactly full store, then one that overflows and drops its own final word
    send_set(DefMaxElements);
    send_set(DefMaxElements + 3);
    wait_for_results();

    // small random sets for the rest
    while (items_sent < NumDirected + RandomItems) begin
      if ($urandom_range(0, 9) == 0) begin
        wait_for_results();
      end
      send_set($urandom_range(1, 12));
    end

    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_words_q.size() != 0) begin
      note_failure($sformatf("%0d words never came out", pending_words_q.size()));
    end
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: binary_insertion_sorter_unit.f
+incdir+src
src/bis_pkg.sv
src/bis_store.sv
src/bis_stats.sv
src/binary_insertion_sorter_unit.sv
tb/tb_binary_insertion_sorter_unit.sv
